// ----- design/sva_pkg.sv -----
// Package for the sound voice allocator: field widths, stream packing offsets,
// mode bits, register indexes and the command type passed from front to back.
// No dependencies.
package sva_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int SOUND_W = 10;
    localparam int SLOT_W  = 4;
    localparam int PAN_W   = 8;
    localparam int VOL_W   = 8;
    localparam int BASE_W  = 9;
    localparam int MODE_W  = 4;
    localparam int PRI_W   = 10;
    localparam int CL_W    = 5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // input tdata offsets
    localparam int IN_SOUND_LO = 0;
    localparam int IN_END_LO   = IN_SOUND_LO + SOUND_W;
    localparam int IN_PAN_LO   = IN_END_LO + SLOT_W;
    localparam int IN_VOL_LO   = IN_PAN_LO + PAN_W;
    localparam int IN_BASE_LO  = IN_VOL_LO + VOL_W;
    localparam int IN_MODE_LO  = IN_BASE_LO + BASE_W;

    // mode bit positions
    localparam int MODE_ONE = 0;
    localparam int MODE_FEW = 1;
    localparam int MODE_CUT = 2;
    localparam int MODE_MAX = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIMIT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_PRIORITY = CFG_IDX_W'(1);

    localparam logic [CL_W-1:0]  COPY_LIMIT_RST = CL_W'(2);
    localparam logic [PRI_W-1:0] TOP_PRI_RST    = PRI_W'(1023);

    typedef struct packed {
        logic               is_end;
        logic               end_ok;
        logic [SLOT_W-1:0]  end_slot;
        logic [SOUND_W-1:0] sound;
        logic [PAN_W-1:0]   pan;
        logic [VOL_W-1:0]   vol;
        logic [PRI_W-1:0]   pri;
        logic [MODE_W-1:0]  mode;
    } cmd_t;

endpackage

// ----- design/sva_front.sv -----
// Front end: accepts stream transactions, decodes the fields, computes the
// request priority and range-checks the ended slot. Depends on sva_pkg.
module sva_front #(
    parameter int SLOT_COUNT = sva_pkg::SLOT_COUNT_DEF
) (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sva_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic [sva_pkg::PRI_W-1:0]        top_priority,
    output logic                             push,
    output sva_pkg::cmd_t                    push_data,
    input  logic                             full
);
    import sva_pkg::*;

    logic [BASE_W-1:0] base;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;
    assign base     = s_tdata[IN_BASE_LO +: BASE_W];

    always_comb
    begin
        push_data          = '0;
        push_data.is_end   = s_tuser;
        push_data.end_slot = s_tdata[IN_END_LO +: SLOT_W];
        push_data.end_ok   = int'(push_data.end_slot) < SLOT_COUNT;
        push_data.sound    = s_tdata[IN_SOUND_LO +: SOUND_W];
        push_data.pan      = s_tdata[IN_PAN_LO +: PAN_W];
        push_data.vol      = s_tdata[IN_VOL_LO +: VOL_W];
        push_data.mode     = s_tdata[IN_MODE_LO +: MODE_W];
        if (push_data.mode[MODE_MAX])
        begin
            push_data.pri = top_priority;
        end
        else
        begin
            push_data.pri = PRI_W'(base) + PRI_W'(push_data.vol);
        end
    end

endmodule

// ----- design/sva_queue.sv -----
// Short command queue between front and back end.
// Depends on sva_pkg for the command type.
module sva_queue #(
    parameter int DEPTH = sva_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sva_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output sva_pkg::cmd_t pop_data,
    output logic          empty
);
    import sva_pkg::*;

    localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          buf_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    assign full     = cnt_reg == NW'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/sva_back.sv -----
// Back end: slot table, one-entry-per-cycle scan sequencer, allocation
// decision and result register. Depends on sva_pkg.
module sva_back #(
    parameter int SLOT_COUNT = sva_pkg::SLOT_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sva_pkg::cmd_t                 q_data,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [sva_pkg::CL_W-1:0]      copy_limit,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sva_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sva_pkg::*;

    localparam int IW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int EW = IW > SLOT_W ? IW : SLOT_W;
    localparam int KW = CW > CL_W ? CW : CL_W;
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    logic [IW-1:0]         addr_reg, addr_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SLOT_COUNT-1:0] playing_reg, playing_next;

    logic [SOUND_W-1:0] sound_mem [SLOT_COUNT];
    logic [PRI_W-1:0]   prio_mem  [SLOT_COUNT];
    logic [SOUND_W-1:0] rd_sound_reg;
    logic [PRI_W-1:0]   rd_prio_reg;
    logic               p_vld_reg, p_vld_next;
    logic [IW-1:0]      p_idx_reg, p_idx_next;

    logic               match_found_reg, match_found_next;
    logic [IW-1:0]      match_idx_reg, match_idx_next;
    logic               match_play_reg, match_play_next;
    logic               pm_found_reg, pm_found_next;
    logic [IW-1:0]      pm_idx_reg, pm_idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               free_fresh_reg, free_fresh_next;
    logic               cand_found_reg, cand_found_next;
    logic [IW-1:0]      cand_idx_reg, cand_idx_next;
    logic [PRI_W-1:0]   cand_pri_reg, cand_pri_next;
    logic               cand_fresh_reg, cand_fresh_next;

    logic                  out_vld_reg, out_vld_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic          p_used, p_play, p_same, p_match;
    logic [EW-1:0] end_wide, slot_wide;
    logic          cut, acc, fresh, mem_we;
    logic [IW-1:0] take_idx;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign p_used    = used_reg[p_idx_reg];
    assign p_play    = playing_reg[p_idx_reg];
    assign p_same    = rd_sound_reg == cmd_reg.sound;
    assign p_match   = p_used && p_same;
    assign end_wide  = EW'(q_data.end_slot);
    assign slot_wide = EW'(take_idx);
    assign cut       = cmd_reg.mode[MODE_CUT];

    // allocation decision over the scan results
    always_comb
    begin
        acc      = 1'b0;
        fresh    = 1'b0;
        take_idx = '0;
        if (cmd_reg.mode[MODE_ONE] && match_found_reg)
        begin
            if (cut || !match_play_reg)
            begin
                acc      = 1'b1;
                take_idx = match_idx_reg;
            end
        end
        else if (cmd_reg.mode[MODE_FEW] && (KW'(count_reg) >= KW'(copy_limit)))
        begin
            if (cut && pm_found_reg)
            begin
                acc      = 1'b1;
                take_idx = pm_idx_reg;
            end
        end
        else if (free_found_reg)
        begin
            acc      = 1'b1;
            take_idx = free_idx_reg;
            fresh    = free_fresh_reg;
        end
        else if (cand_found_reg)
        begin
            acc      = 1'b1;
            take_idx = cand_idx_reg;
            fresh    = cand_fresh_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        used_next        = used_reg;
        playing_next     = playing_reg;
        p_vld_next       = (state_reg == ST_SCAN);
        p_idx_next       = addr_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_play_next  = match_play_reg;
        pm_found_next    = pm_found_reg;
        pm_idx_next      = pm_idx_reg;
        count_next       = count_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        free_fresh_next  = free_fresh_reg;
        cand_found_next  = cand_found_reg;
        cand_idx_next    = cand_idx_reg;
        cand_pri_next    = cand_pri_reg;
        cand_fresh_next  = cand_fresh_reg;
        out_vld_next     = out_vld_reg;
        out_data_next    = out_data_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;

        if (p_vld_reg)
        begin
            if (p_match && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = p_idx_reg;
                match_play_next  = p_play;
            end
            if (p_match && p_play)
            begin
                count_next = count_reg + CW'(1);
                if (!pm_found_reg)
                begin
                    pm_found_next = 1'b1;
                    pm_idx_next   = p_idx_reg;
                end
            end
            if (!free_found_reg)
            begin
                if (!p_used || !p_play)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = p_idx_reg;
                    free_fresh_next = !p_used || !p_same;
                end
                else if (((rd_prio_reg < cmd_reg.pri) || (p_same && cut)) &&
                         (!cand_found_reg || (rd_prio_reg < cand_pri_reg)))
                begin
                    cand_found_next = 1'b1;
                    cand_idx_next   = p_idx_reg;
                    cand_pri_next   = rd_prio_reg;
                    cand_fresh_next = !p_same;
                end
            end
        end

        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.is_end)
                    begin
                        if (q_data.end_ok)
                        begin
                            playing_next[end_wide[IW-1:0]] = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd_next         = q_data;
                        addr_next        = '0;
                        match_found_next = 1'b0;
                        pm_found_next    = 1'b0;
                        count_next       = '0;
                        free_found_next  = 1'b0;
                        cand_found_next  = 1'b0;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + IW'(1);
                if (addr_reg == LAST)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (acc)
                    begin
                        used_next[take_idx]    = 1'b1;
                        playing_next[take_idx] = 1'b1;
                        mem_we                 = 1'b1;
                        out_data_next = {cmd_reg.vol, cmd_reg.pan, cmd_reg.sound, fresh,
                                         slot_wide[SLOT_W-1:0], 1'b1};
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= '0;
            addr_reg        <= '0;
            used_reg        <= '0;
            playing_reg     <= '0;
            p_vld_reg       <= 1'b0;
            p_idx_reg       <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            match_play_reg  <= 1'b0;
            pm_found_reg    <= 1'b0;
            pm_idx_reg      <= '0;
            count_reg       <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            free_fresh_reg  <= 1'b0;
            cand_found_reg  <= 1'b0;
            cand_idx_reg    <= '0;
            cand_pri_reg    <= '0;
            cand_fresh_reg  <= 1'b0;
            out_vld_reg     <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            addr_reg        <= addr_next;
            used_reg        <= used_next;
            playing_reg     <= playing_next;
            p_vld_reg       <= p_vld_next;
            p_idx_reg       <= p_idx_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            match_play_reg  <= match_play_next;
            pm_found_reg    <= pm_found_next;
            pm_idx_reg      <= pm_idx_next;
            count_reg       <= count_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            free_fresh_reg  <= free_fresh_next;
            cand_found_reg  <= cand_found_next;
            cand_idx_reg    <= cand_idx_next;
            cand_pri_reg    <= cand_pri_next;
            cand_fresh_reg  <= cand_fresh_next;
            out_vld_reg     <= out_vld_next;
            out_data_reg    <= out_data_next;
        end
    end

    // slot sound and priority table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sound_mem[take_idx] <= cmd_reg.sound;
            prio_mem[take_idx]  <= cmd_reg.pri;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_sound_reg <= sound_mem[addr_reg];
            rd_prio_reg  <= prio_mem[addr_reg];
        end
    end

endmodule

// ----- design/sound_voice_allocator.sv -----
// Top level of the sound voice allocator: configuration registers, front end,
// command queue and back end. Depends on sva_pkg, sva_front, sva_queue, sva_back.
//
//  channel | signals                          | carries
//  --------+----------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser| play request / voice ended
//  m_      | m_tvalid m_tready m_tdata        | allocation result per play
//  cfg_    | cfg_valid cfg_ready cfg_index    | register writes, always ready
//          | cfg_data                         |
//
// A play request is handled in the back end by a scan of the slot table, one entry
// per cycle through its read port, followed by a flush state and a decide state.
// A voice-ended transaction is handled in the idle state and gives no result.
// The queue holds QUEUE_DEPTH commands; input stalls only when it is full.
// A stalled result holds in its output register; the next decision waits on it.
// Reset clears slot state and loads copy_limit 2, top_priority 1023.
module sound_voice_allocator #(
    parameter int SLOT_COUNT = sva_pkg::SLOT_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sound_id[9:0] end_slot[13:10] pan[21:14] volume[29:22]
    // base_priority[38:30] mode_flags[42:39], zero fill above
    input  logic [sva_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accepted[0] slot[4:1] new_voice[5] out_sound[15:6] out_pan[23:16]
    // out_volume[31:24]
    output logic [sva_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sva_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sva_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sva_pkg::*;

    logic [CL_W-1:0]  copy_limit_reg;
    logic [PRI_W-1:0] top_pri_reg;
    logic             push, full, pop, empty;
    cmd_t             push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_limit_reg <= COPY_LIMIT_RST;
            top_pri_reg    <= TOP_PRI_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COPY_LIMIT:   copy_limit_reg <= cfg_data[CL_W-1:0];
                CFG_TOP_PRIORITY: top_pri_reg    <= cfg_data[PRI_W-1:0];
                default:          ;
            endcase
        end
    end

    sva_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .top_priority(top_pri_reg),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    sva_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty)
    );

    sva_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (pop_data),
        .q_empty   (empty),
        .q_pop     (pop),
        .copy_limit(copy_limit_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- design/sva_checker.sv -----
// Port-level checks for the sound voice allocator, bound to the top level.
// Depends on sva_pkg and sound_voice_allocator.
module sva_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sva_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           cfg_ready
);
    import sva_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // rejected result carries all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_DATA_W-1:1] == '0)
        else $error("rejected result with nonzero fields");

    // no result right after a reset edge, config always takes writes
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && cfg_ready)
        else $error("result valid during reset");

endmodule

bind sound_voice_allocator sva_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);

// ----- tb/tb.sv -----
// Testbench for sound_voice_allocator: a scoreboard mirrors the slot table and checks
// every allocation result, with directed and random stimulus, idling on both streams.
// Depends on sva_pkg and the sound_voice_allocator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = sva_pkg::SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 170;

    localparam logic [3:0] ONE_COPY = 4'(1 << sva_pkg::MODE_ONE);
    localparam logic [3:0] FEW_COPIES = 4'(1 << sva_pkg::MODE_FEW);
    localparam logic [3:0] CUTOFF = 4'(1 << sva_pkg::MODE_CUT);
    localparam logic [3:0] MAX_PRI = 4'(1 << sva_pkg::MODE_MAX);
    localparam logic [sva_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'd200;

    typedef struct packed {
        logic       action;
        logic [9:0] sound;
        logic [3:0] end_slot;
        logic [7:0] pan;
        logic [7:0] vol;
        logic [8:0] base;
        logic [3:0] mode;
    } voice_req_t;

    typedef struct packed {
        logic       accepted;
        logic [3:0] slot;
        logic       new_voice;
        logic [9:0] sound;
        logic [7:0] pan;
        logic [7:0] vol;
    } grant_t;

    class voice_scoreboard;
        logic [4:0] copy_limit;
        logic [9:0] top_priority;
        bit         used[SLOTS];
        bit         playing[SLOTS];
        logic [9:0] sound[SLOTS];
        logic [9:0] prio[SLOTS];
        logic [7:0] pan[SLOTS];
        logic [7:0] vol[SLOTS];
        logic [3:0] mode[SLOTS];
        grant_t     pending_grants[$];
        int         failures;
        int         n_requests;
        int         n_ended;
        int         n_granted;
        int         n_rejected;
        int         n_fresh;
        int         n_writes;

        function new();
            copy_limit = sva_pkg::COPY_LIMIT_RST;
            top_priority = sva_pkg::TOP_PRI_RST;
            for (int i = 0; i < SLOTS; i++)
            begin
                used[i] = 0;
                playing[i] = 0;
                sound[i] = '0;
                prio[i] = '0;
                pan[i] = '0;
                vol[i] = '0;
                mode[i] = '0;
            end
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] data);
            n_writes++;
            if (idx == sva_pkg::CFG_COPY_LIMIT)
                copy_limit = data[4:0];
            else if (idx == sva_pkg::CFG_TOP_PRIORITY)
                top_priority = data[9:0];
        endfunction

        function void start_voice(int s, logic [9:0] pri, voice_req_t r, bit fresh,
                                  output grant_t g);
            prio[s] = pri;
            pan[s] = r.pan;
            vol[s] = r.vol;
            mode[s] = r.mode;
            playing[s] = 1;
            g.accepted = 1;
            g.slot = 4'(s);
            g.new_voice = fresh;
            g.sound = r.sound;
            g.pan = r.pan;
            g.vol = r.vol;
        endfunction

        // returns 1 when the request produces a result
        function bit allocate(voice_req_t r, output grant_t g);
            int         best;
            int         copies;
            logic [9:0] pri;
            bit         cut;
            bit         fresh;
            g = '0;
            if (r.action)
            begin
                if (int'(r.end_slot) < SLOTS)
                    playing[r.end_slot] = 0;
                return 0;
            end
            cut = r.mode[sva_pkg::MODE_CUT];
            pri = r.mode[sva_pkg::MODE_MAX] ? top_priority : 10'(r.base) + 10'(r.vol);
            if (r.mode[sva_pkg::MODE_ONE])
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (used[i] && sound[i] == r.sound)
                    begin
                        if (cut || !playing[i])
                            start_voice(i, pri, r, 0, g);
                        return 1;
                    end
                end
            end
            if (r.mode[sva_pkg::MODE_FEW])
            begin
                copies = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (used[i] && sound[i] == r.sound && playing[i])
                        copies++;
                if (copies >= int'(copy_limit))
                begin
                    if (cut)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (used[i] && sound[i] == r.sound && playing[i])
                            begin
                                start_voice(i, pri, r, 0, g);
                                return 1;
                            end
                        end
                    end
                    return 1;
                end
            end
            best = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!used[i] || !playing[i])
                begin
                    best = i;
                    break;
                end
                if (prio[i] < pri || (sound[i] == r.sound && cut))
                    if (best < 0 || prio[i] < prio[best])
                        best = i;
            end
            if (best < 0)
                return 1;
            fresh = !used[best] || sound[best] != r.sound;
            used[best] = 1;
            sound[best] = r.sound;
            start_voice(best, pri, r, fresh, g);
            return 1;
        endfunction

        function void note_request(voice_req_t r);
            grant_t g;
            if (allocate(r, g))
            begin
                n_requests++;
                pending_grants.push_back(g);
                if (g.accepted)
                    n_granted++;
                else
                    n_rejected++;
                if (g.new_voice)
                    n_fresh++;
            end
            else
                n_ended++;
        endfunction

        function void check_grant(logic [sva_pkg::OUT_DATA_W-1:0] data);
            grant_t want;
            if (pending_grants.size() == 0)
            begin
                $error("result 0x%08h with no request outstanding", data);
                failures++;
                return;
            end
            want = pending_grants.pop_front();
            if (data[0] !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, data[0]);
                failures++;
            end
            if (data[4:1] !== want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, data[4:1]);
                failures++;
            end
            if (data[5] !== want.new_voice)
            begin
                $error("new_voice: expected %0d, got %0d", want.new_voice, data[5]);
                failures++;
            end
            if (data[15:6] !== want.sound)
            begin
                $error("out_sound: expected %0d, got %0d", want.sound, data[15:6]);
                failures++;
            end
            if (data[23:16] !== want.pan)
            begin
                $error("out_pan: expected %0d, got %0d", want.pan, data[23:16]);
                failures++;
            end
            if (data[31:24] !== want.vol)
            begin
                $error("out_volume: expected %0d, got %0d", want.vol, data[31:24]);
                failures++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [sva_pkg::IN_DATA_W-1:0]     s_tdata = '0;
    logic                              s_tuser = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [sva_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sva_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [sva_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    voice_scoreboard sb = new();
    bit              steady = 0;
    int              cycles = 0;

    sound_voice_allocator #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 33);

    // outputs and ready are stable from the falling edge up to the accepting edge
    always @(negedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_grant(m_tdata);

    task automatic send_request(voice_req_t r);
        bit taken;
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.action;
        s_tdata <= sva_pkg::IN_DATA_W'({r.mode, r.base, r.vol, r.pan, r.end_slot, r.sound});
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            if (s_tready)
            begin
                taken = 1;
                sb.note_request(r);
            end
            @(posedge clk);
        end
    endtask

    task automatic play(logic [9:0] snd, logic [7:0] pan, logic [7:0] vol, logic [8:0] base,
                        logic [3:0] mode);
        voice_req_t r;
        r = '{action: 1'b0, sound: snd, end_slot: 4'($urandom), pan: pan, vol: vol,
              base: base, mode: mode};
        send_request(r);
    endtask

    task automatic voice_ended(logic [3:0] slot);
        voice_req_t r;
        r = '{action: 1'b1, sound: 10'($urandom), end_slot: slot, pan: 8'($urandom),
              vol: 8'($urandom), base: 9'($urandom), mode: 4'($urandom)};
        send_request(r);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            if (cfg_ready)
            begin
                taken = 1;
                sb.write_reg(idx, data);
            end
            @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int items, int end_pct);
        logic [9:0] pool[4];
        voice_req_t r;
        pool[0] = $urandom_range(0, 1) ? 10'd0 : 10'h3FF;
        for (int k = 1; k < 4; k++)
            pool[k] = 10'($urandom);
        for (int n = 0; n < items; n++)
        begin
            r.action = $urandom_range(0, 99) < end_pct;
            r.sound = ($urandom_range(0, 9) == 0) ? 10'($urandom) : pool[$urandom_range(0, 3)];
            r.end_slot = 4'($urandom);
            r.pan = 8'($urandom);
            r.vol = 8'($urandom);
            r.base = 9'($urandom);
            r.mode = 4'($urandom);
            send_request(r);
        end
    endtask

    initial
    begin
        logic [15:0] limit_set[PHASES];
        logic [15:0] top_set[PHASES];
        int          end_pct[PHASES];

        limit_set = '{16'd1, 16'd16, 16'd0, 16'hFFFF, {11'($urandom), 5'($urandom_range(1, 16))},
                      16'd2};
        top_set = '{16'd0, 16'd1023, 16'd512, 16'hFFFF, 16'($urandom), 16'($urandom_range(0, 1023))};
        end_pct = '{25, 10, 35, 20, 30, 40};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        play(10'd0, 8'd0, 8'd0, 9'd0, 4'd0);
        play(10'h3FF, 8'hFF, 8'hFF, 9'h1FF, 4'd0);
        play(10'd0, 8'd10, 8'd20, 9'd30, ONE_COPY);
        play(10'd0, 8'd11, 8'd21, 9'd31, ONE_COPY | CUTOFF);
        voice_ended(4'd0);
        voice_ended(4'd0);
        play(10'd0, 8'd12, 8'd22, 9'd32, ONE_COPY);
        play(10'd5, 8'd40, 8'd50, 9'd60, FEW_COPIES);
        play(10'd5, 8'd41, 8'd51, 9'd61, FEW_COPIES);
        play(10'd5, 8'd42, 8'd52, 9'd62, FEW_COPIES);
        play(10'd5, 8'd43, 8'd53, 9'd63, FEW_COPIES | CUTOFF);
        play(10'd7, 8'd70, 8'd1, 9'd1, MAX_PRI);
        voice_ended(4'd15);
        voice_ended(4'd1);
        play(10'd9, 8'h80, 8'h7F, 9'h100, 4'd0);
        play(10'd9, 8'h55, 8'hAA, 9'h0AA, ONE_COPY | FEW_COPIES | CUTOFF | MAX_PRI);
        play(10'h3FF, 8'h01, 8'hFE, 9'h155, ONE_COPY | FEW_COPIES);
        play(10'h2AA, 8'h33, 8'hCC, 9'h0F0, FEW_COPIES | CUTOFF);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(sva_pkg::CFG_COPY_LIMIT, limit_set[p]);
            write_reg(sva_pkg::CFG_TOP_PRIORITY, top_set[p]);
            if (p == 2)
                write_reg(CFG_NO_REG, 16'($urandom));
            cfg_valid <= 1'b0;
            steady = (p == 1);
            random_phase(PHASE_ITEMS, end_pct[p]);
            drain();
        end

        $display("%0d play requests and %0d voice-ended events over %0d register writes",
                 sb.n_requests, sb.n_ended, sb.n_writes);
        $display("%0d voices granted (%0d new), %0d requests turned away",
                 sb.n_granted, sb.n_fresh, sb.n_rejected);
        if (sb.failures == 0 && sb.pending_grants.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
